@@ sv/nfba_pkg.sv @@
// Shared codes and state encoding for the next-fit block allocator.
`default_nettype none
package nfba_pkg;

	localparam logic [2:0] OP_CLEAR   = 3'd0;
	localparam logic [2:0] OP_RELEASE = 3'd1;
	localparam logic [2:0] OP_ALLOC   = 3'd2;
	localparam logic [2:0] OP_FREE    = 3'd3;
	localparam logic [2:0] OP_QUERY   = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_INIT  = 3'd1;
	localparam logic [2:0] ST_NO_SPACE  = 3'd2;
	localparam logic [2:0] ST_NOT_HDR   = 3'd3;
	localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

	localparam logic [1:0] HS_FREE = 2'd0;
	localparam logic [1:0] HS_USED = 2'd1;
	localparam logic [1:0] HS_END  = 2'd2;

	localparam int BYTES_W = 16;
	localparam int UNITS_W = 17;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_DECODE,
		S_DIV,
		S_TOP,
		S_HDR,
		S_MRD,
		S_MCHK,
		S_FIT,
		S_TAKE,
		S_FCHK,
		S_CLR2
	} state_t;

endpackage
`default_nettype wire

@@ sv/nfba_div.sv @@
// Size rounding unit that turns a byte count into whole units, rounding up with a shift.
`default_nettype none
module nfba_div #(
	parameter int UNIT_BYTES = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         go,
	input  wire logic [nfba_pkg::BYTES_W-1:0] bytes,
	output logic                              done,
	output logic [nfba_pkg::UNITS_W-1:0]      quot
);
	import nfba_pkg::*;

	// The unit size is a power of two, so the division is a right shift.
	localparam int SH = $clog2(UNIT_BYTES);

	logic [UNITS_W-1:0] quot_q;
	logic               done_q;
	logic [UNITS_W-1:0] num;

	assign num = {1'b0, bytes} + UNITS_W'(UNIT_BYTES - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= go;
			if (go)
				quot_q <= num >> SH;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

@@ sv/next_fit_block_allocator.sv @@
// Next-fit block allocator: sequencer, header memory and configuration port.
//
// A request is taken when start is high and busy is low; opcode, request_bytes
// and block_address are sampled then. Each request gives exactly one result,
// shown for a single cycle with done high, together with status,
// result_address and is_valid. The receiver cannot stall, so results are
// never held.
// After reset the block sweeps the header memory to zero, one entry a cycle,
// so busy stays high until the sweep ends, before the first request.
// Clear writes the first header while decoding, then the end header; release
// finishes in decode; free reads the header while decoding, then checks it
// and, if it is in use, writes it back as free. Allocation decodes, starts
// the rounding and waits for the unit count, then walks the headers, a read
// and a check each, examines each neighbour while merging, settles each free
// block and takes the chosen block; a second pass from the base may follow.
// A query decodes and walks the headers alike; each result is registered.
// The walk over the header memory, one read a step, sets the rate; pool_units
// is written over the APB port at byte address 0 and is only used by clear.
`default_nettype none
module next_fit_block_allocator #(
	parameter int POOL_DEPTH = 4096,
	parameter int UNIT_BYTES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  opcode,
	input  wire logic [15:0] request_bytes,
	input  wire logic [11:0] block_address,
	output logic             done,
	output logic [2:0]       status,
	output logic [11:0]      result_address,
	output logic             is_valid,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import nfba_pkg::*;

	localparam int AW = $clog2(POOL_DEPTH);
	localparam int CW = AW + 1;
	localparam int HW = AW + 3;
	localparam int SW = $clog2(POOL_DEPTH + 2);

	// Header memory
	logic [HW-1:0] mem [POOL_DEPTH];
	logic [HW-1:0] mem_rd_q;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [HW-1:0] mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			mem_rd_q <= mem[mem_ra];
	end

	state_t state_q, state_d;
	logic [2:0]          op_q, op_d;
	logic [15:0]         bytes_q, bytes_d;
	logic [11:0]         addr_q, addr_d;
	logic [CW-1:0]       c_q, c_d, n_q, n_d, ss_q, ss_d;
	logic [AW-1:0]       csize_q, csize_d, sweep_q, sweep_d;
	logic [SW-1:0]       steps_q, steps_d;
	logic                base_q, base_d, ready_q, ready_d;
	logic [UNITS_W-1:0]  units_q, units_d;
	logic [12:0]         pool_units_q;
	logic                done_q, done_d, valid_q, valid_d;
	logic [2:0]          status_q, status_d;
	logic [11:0]         res_q, res_d;

	logic               div_go, div_done;
	logic [UNITS_W-1:0] div_quot;

	nfba_div #(.UNIT_BYTES(UNIT_BYTES)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.bytes  (bytes_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	logic          hdr_mark;
	logic [1:0]    hdr_stat;
	logic [AW-1:0] hdr_size;
	logic [AW-1:0] add_b;
	logic [CW-1:0] nxt;
	logic          fit, split, pass_fail;
	logic [AW-1:0] diff;
	logic [CW-1:0] n_clr;
	logic [AW-1:0] fidx;

	assign hdr_mark = mem_rd_q[AW+2];
	assign hdr_stat = mem_rd_q[AW+1:AW];
	assign hdr_size = mem_rd_q[AW-1:0];
	assign fit      = 32'(csize_q) >= 32'(units_q);
	assign diff     = AW'(csize_q - AW'(units_q));
	assign split    = diff > AW'(1);
	assign fidx     = AW'(32'(addr_q) - 1);

	// The shared adder: address of the header after a block of add_b units.
	always_comb begin
		if (state_q == S_HDR)
			add_b = hdr_size;
		else if (state_q == S_FIT && fit)
			add_b = AW'(units_q);
		else
			add_b = csize_q;
		nxt = CW'(c_q + CW'(1) + CW'(add_b));
	end

	always_comb begin
		if (pool_units_q < 13'd3)
			n_clr = CW'(3);
		else if (32'(pool_units_q) > POOL_DEPTH)
			n_clr = CW'(POOL_DEPTH);
		else
			n_clr = CW'(pool_units_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_SWEEP;
			sweep_q  <= '0;
			ready_q  <= 1'b0;
			ss_q     <= '0;
			done_q   <= 1'b0;
			op_q     <= OP_CLEAR;
			base_q   <= 1'b0;
			steps_q  <= '0;
		end else begin
			state_q  <= state_d;
			sweep_q  <= sweep_d;
			ready_q  <= ready_d;
			ss_q     <= ss_d;
			done_q   <= done_d;
			op_q     <= op_d;
			base_q   <= base_d;
			steps_q  <= steps_d;
		end
	end

	always_ff @(posedge clk) begin
		bytes_q  <= bytes_d;
		addr_q   <= addr_d;
		c_q      <= c_d;
		n_q      <= n_d;
		csize_q  <= csize_d;
		units_q  <= units_d;
		status_q <= status_d;
		res_q    <= res_d;
		valid_q  <= valid_d;
	end

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		bytes_d   = bytes_q;
		addr_d    = addr_q;
		c_d       = c_q;
		n_d       = n_q;
		ss_d      = ss_q;
		csize_d   = csize_q;
		sweep_d   = sweep_q;
		steps_d   = steps_q;
		base_d    = base_q;
		ready_d   = ready_q;
		units_d   = units_q;
		done_d    = 1'b0;
		status_d  = status_q;
		res_d     = res_q;
		valid_d   = valid_q;
		mem_we    = 1'b0;
		mem_wa    = c_q[AW-1:0];
		mem_wd    = '0;
		mem_re    = 1'b0;
		mem_ra    = c_q[AW-1:0];
		div_go    = 1'b0;
		pass_fail = 1'b0;

		unique case (state_q)
			S_SWEEP: begin
				mem_we  = 1'b1;
				mem_wa  = sweep_q;
				sweep_d = AW'(sweep_q + 1'b1);
				if (sweep_q == AW'(POOL_DEPTH - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					op_d     = opcode;
					bytes_d  = request_bytes;
					addr_d   = block_address;
					status_d = ST_OK;
					res_d    = '0;
					valid_d  = 1'b0;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (op_q)
					OP_CLEAR: begin
						mem_we  = 1'b1;
						mem_wa  = '0;
						mem_wd  = {1'b1, HS_FREE, AW'(n_clr - CW'(2))};
						state_d = S_CLR2;
					end
					OP_RELEASE: begin
						if (!ready_q)
							status_d = ST_NOT_INIT;
						else
							ready_d = 1'b0;
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
					OP_ALLOC: begin
						if (!ready_q) begin
							status_d = ST_NOT_INIT;
							done_d   = 1'b1;
							state_d  = S_IDLE;
						end else begin
							div_go  = 1'b1;
							state_d = S_DIV;
						end
					end
					OP_FREE: begin
						if (!ready_q) begin
							status_d = ST_NOT_INIT;
							done_d   = 1'b1;
							state_d  = S_IDLE;
						end else if (addr_q == 12'd0 || 32'(addr_q) > POOL_DEPTH) begin
							status_d = ST_NOT_HDR;
							done_d   = 1'b1;
							state_d  = S_IDLE;
						end else begin
							mem_re  = 1'b1;
							mem_ra  = fidx;
							state_d = S_FCHK;
						end
					end
					OP_QUERY: begin
						if (!ready_q) begin
							status_d = ST_NOT_INIT;
							done_d   = 1'b1;
							state_d  = S_IDLE;
						end else begin
							c_d     = '0;
							steps_d = '0;
							state_d = S_TOP;
						end
					end
					default: begin
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			S_DIV: begin
				if (div_done) begin
					units_d = div_quot;
					c_d     = ss_q;
					base_d  = 1'b0;
					steps_d = '0;
					state_d = S_TOP;
				end
			end
			S_TOP: begin
				if (steps_q > SW'(POOL_DEPTH) || c_q >= CW'(POOL_DEPTH)) begin
					if (op_q == OP_QUERY) begin
						done_d  = 1'b1;
						state_d = S_IDLE;
					end else begin
						pass_fail = 1'b1;
					end
				end else begin
					mem_re  = 1'b1;
					state_d = S_HDR;
				end
			end
			S_HDR: begin
				if (op_q == OP_QUERY) begin
					if (!hdr_mark) begin
						done_d  = 1'b1;
						state_d = S_IDLE;
					end else if (32'(c_q) + 1 == 32'(addr_q) || hdr_stat == HS_END) begin
						valid_d = hdr_stat == HS_USED;
						done_d  = 1'b1;
						state_d = S_IDLE;
					end else begin
						c_d     = nxt;
						steps_d = SW'(steps_q + 1'b1);
						state_d = S_TOP;
					end
				end else if (!hdr_mark) begin
					pass_fail = 1'b1;
				end else if (hdr_stat == HS_USED) begin
					c_d     = nxt;
					steps_d = SW'(steps_q + 1'b1);
					if (base_q && !(nxt < ss_q))
						pass_fail = 1'b1;
					else
						state_d = S_TOP;
				end else if (hdr_stat == HS_FREE) begin
					csize_d = hdr_size;
					state_d = S_MRD;
				end else begin
					pass_fail = 1'b1;
				end
			end
			S_MRD: begin
				if (nxt >= CW'(POOL_DEPTH)) begin
					state_d = S_FIT;
				end else begin
					mem_re  = 1'b1;
					mem_ra  = nxt[AW-1:0];
					n_d     = nxt;
					state_d = S_MCHK;
				end
			end
			S_MCHK: begin
				if (hdr_mark && hdr_stat == HS_FREE) begin
					csize_d = AW'(csize_q + hdr_size + 1'b1);
					// A merge that swallows the saved start moves it back here.
					if (n_q == ss_q)
						ss_d = c_q;
					state_d = S_MRD;
				end else begin
					state_d = S_FIT;
				end
			end
			S_FIT: begin
				if (fit) begin
					if (split) begin
						mem_we  = 1'b1;
						mem_wa  = nxt[AW-1:0];
						mem_wd  = {1'b1, HS_FREE, AW'(diff - 1'b1)};
						csize_d = AW'(units_q);
					end
					state_d = S_TAKE;
				end else begin
					mem_we  = 1'b1;
					mem_wd  = {1'b1, HS_FREE, csize_q};
					c_d     = nxt;
					steps_d = SW'(steps_q + 1'b1);
					if (base_q && !(nxt < ss_q))
						pass_fail = 1'b1;
					else
						state_d = S_TOP;
				end
			end
			S_TAKE: begin
				mem_we  = 1'b1;
				mem_wd  = {1'b1, HS_USED, csize_q};
				ss_d    = nxt;
				res_d   = 12'(c_q + 1'b1);
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			S_FCHK: begin
				if (!hdr_mark) begin
					status_d = ST_NOT_HDR;
				end else if (hdr_stat != HS_USED) begin
					status_d = ST_NOT_ALLOC;
				end else begin
					mem_we = 1'b1;
					mem_wa = fidx;
					mem_wd = {1'b1, HS_FREE, hdr_size};
				end
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			S_CLR2: begin
				mem_we  = 1'b1;
				mem_wa  = AW'(n_clr - CW'(1));
				mem_wd  = {1'b1, HS_END, AW'(0)};
				ss_d    = '0;
				ready_d = 1'b1;
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// A failed pass from the saved start retries once from the pool base.
		if (pass_fail) begin
			if (base_q) begin
				status_d = ST_NO_SPACE;
				done_d   = 1'b1;
				state_d  = S_IDLE;
			end else begin
				base_d  = 1'b1;
				c_d     = '0;
				steps_d = '0;
				state_d = S_TOP;
			end
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pool_units_q <= 13'd4096;
		else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
			pool_units_q <= pwdata[12:0];
	end

	assign prdata = (paddr[2] == 1'b0) ? 32'(pool_units_q) : 32'd0;
	assign pready = 1'b1;

	assign busy           = state_q != S_IDLE;
	assign done           = done_q;
	assign status         = status_q;
	assign result_address = res_q;
	assign is_valid       = valid_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while a request is still in progress");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after taking a request");
	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> result_address == 12'd0)
		else $error("failed request carries an address");
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_valid |-> status == ST_OK)
		else $error("validity answer with an error status");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the next-fit block allocator: directed and random requests.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import nfba_pkg::*;

	localparam int DEPTH = 4096;
	localparam int UNIT = 16;
	localparam int STALL_LIMIT = 400000;

	typedef struct {
		logic [2:0]  st;
		logic [11:0] addr;
		logic        valid;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  opcode = OP_CLEAR;
	logic [15:0] request_bytes = '0;
	logic [11:0] block_address = '0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire         busy, done, is_valid, pready;
	wire  [2:0]  status;
	wire  [11:0] result_address;
	wire  [31:0] prdata;

	next_fit_block_allocator i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .request_bytes(request_bytes), .block_address(block_address),
		.done(done), .status(status), .result_address(result_address), .is_valid(is_valid),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state: header memory, next-fit pointer, pool flag and register copy.
	bit          hdr_mark [DEPTH];
	logic [1:0]  hdr_state [DEPTH];
	int unsigned hdr_size [DEPTH];
	int unsigned rover_pos;
	bit          pool_live;
	logic [12:0] pool_units_reg = 13'd4096;

	outcome_t    pending[$];
	logic [11:0] live_blocks[$];
	int          errors, accepted, results, allocs_ok, no_space, frees_ok, queries_true;
	int          idle_cycles;
	bit          gaps_on = 1'b1;

	function automatic bit is_header(int unsigned i);
		return i < DEPTH && hdr_mark[i];
	endfunction

	function automatic int unsigned follow(int unsigned i);
		return i + 1 + hdr_size[i];
	endfunction

	function automatic void coalesce(int unsigned c);
		int unsigned n;
		forever begin
			n = follow(c);
			if (!is_header(n) || hdr_state[n] != HS_FREE)
				return;
			hdr_size[c] += hdr_size[n] + 1;
			if (n == rover_pos)
				rover_pos = c;
		end
	endfunction

	function automatic bit fit_walk(int unsigned from, int unsigned units, bit from_base,
			output int unsigned got);
		int unsigned c;
		logic [1:0] st;
		c = from;
		got = 0;
		for (int steps = 0; steps <= DEPTH; steps++) begin
			if (!is_header(c))
				return 1'b0;
			st = hdr_state[c];
			if (st == HS_FREE) begin
				coalesce(c);
				if (hdr_size[c] >= units) begin
					if (hdr_size[c] - units > 1) begin
						hdr_mark[c + 1 + units] = 1'b1;
						hdr_state[c + 1 + units] = HS_FREE;
						hdr_size[c + 1 + units] = hdr_size[c] - units - 1;
						hdr_size[c] = units;
					end
					hdr_state[c] = HS_USED;
					rover_pos = follow(c);
					got = c;
					return 1'b1;
				end
				c = follow(c);
			end else if (st == HS_USED) begin
				c = follow(c);
			end
			if (from_base) begin
				if (!(c < rover_pos))
					return 1'b0;
			end else if (!is_header(c) || hdr_state[c] == HS_END || st > HS_USED) begin
				return 1'b0;
			end
		end
		return 1'b0;
	endfunction

	function automatic bit holds_used(int unsigned addr);
		int unsigned c;
		c = 0;
		for (int steps = 0; steps <= DEPTH; steps++) begin
			if (!is_header(c))
				return 1'b0;
			if (c + 1 == addr || hdr_state[c] == HS_END)
				return hdr_state[c] == HS_USED;
			c = follow(c);
		end
		return 1'b0;
	endfunction

	function automatic outcome_t predict_request(logic [2:0] op, logic [15:0] bytes,
			logic [11:0] addr);
		outcome_t o;
		int unsigned n, units, got;
		o = '{ST_OK, 12'd0, 1'b0};
		case (op)
			OP_CLEAR: begin
				n = pool_units_reg;
				if (n < 3) n = 3;
				if (n > DEPTH) n = DEPTH;
				hdr_mark[0] = 1'b1; hdr_state[0] = HS_FREE; hdr_size[0] = n - 2;
				hdr_mark[n - 1] = 1'b1; hdr_state[n - 1] = HS_END; hdr_size[n - 1] = 0;
				rover_pos = 0;
				pool_live = 1'b1;
				live_blocks.delete();
			end
			OP_RELEASE: begin
				if (!pool_live) o.st = ST_NOT_INIT;
				else pool_live = 1'b0;
				live_blocks.delete();
			end
			OP_ALLOC: begin
				if (!pool_live) begin
					o.st = ST_NOT_INIT;
				end else begin
					units = (int'(bytes) + UNIT - 1) / UNIT;
					if (fit_walk(rover_pos, units, 1'b0, got) || fit_walk(0, units, 1'b1, got)) begin
						o.addr = 12'(got + 1);
						live_blocks.push_back(o.addr);
						allocs_ok++;
					end else begin
						o.st = ST_NO_SPACE;
						no_space++;
					end
				end
			end
			OP_FREE: begin
				if (!pool_live) begin
					o.st = ST_NOT_INIT;
				end else if (addr == 0 || !is_header(addr - 1)) begin
					o.st = ST_NOT_HDR;
				end else if (hdr_state[addr - 1] != HS_USED) begin
					o.st = ST_NOT_ALLOC;
				end else begin
					hdr_state[addr - 1] = HS_FREE;
					frees_ok++;
					foreach (live_blocks[i])
						if (live_blocks[i] == addr) begin
							live_blocks.delete(i);
							break;
						end
				end
			end
			OP_QUERY: begin
				if (!pool_live) o.st = ST_NOT_INIT;
				else o.valid = holds_used(addr);
				queries_true += o.valid;
			end
			default: ;
		endcase
		return o;
	endfunction

	// Results are checked before the request taken at the same edge is predicted.
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n) begin
			idle_cycles++;
			if (done) begin
				idle_cycles = 0;
				results++;
				if (pending.size() == 0) begin
					$display("%0t: result with no request outstanding: status %0d addr %0d valid %0d",
						$time, status, result_address, is_valid);
					errors++;
				end else begin
					e = pending.pop_front();
					if (status !== e.st) begin
						$display("%0t: status expected %0d actual %0d", $time, e.st, status);
						errors++;
					end
					if (result_address !== e.addr) begin
						$display("%0t: result_address expected %0d actual %0d",
							$time, e.addr, result_address);
						errors++;
					end
					if (is_valid !== e.valid) begin
						$display("%0t: is_valid expected %0d actual %0d", $time, e.valid, is_valid);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				idle_cycles = 0;
				accepted++;
				pending.push_back(predict_request(opcode, request_bytes, block_address));
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles > STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("[next_fit_block_allocator] ERROR");
			$finish;
		end
	end

	// Leaves start high on return, so back-to-back requests need no extra step.
	task automatic send_request(logic [2:0] op, logic [15:0] bytes, logic [11:0] addr);
		while (gaps_on && $urandom_range(99) < 19) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		request_bytes <= bytes;
		block_address <= addr;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_pool_units(logic [12:0] value);
		drain();
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= '0; pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pool_units_reg = value;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [11:0] pick_live();
		if (live_blocks.size() == 0)
			return 12'($urandom_range(DEPTH - 1));
		return live_blocks[$urandom_range(live_blocks.size() - 1)];
	endfunction

	task automatic test_before_clear;
		send_request(OP_ALLOC, 16'd16, 12'd0);
		send_request(OP_FREE, 16'd0, 12'd1);
		send_request(OP_QUERY, 16'd0, 12'd1);
		send_request(OP_RELEASE, 16'd0, 12'd0);
		drain();
	endtask

	task automatic test_directed;
		logic [11:0] a;
		write_pool_units(13'd4096);
		send_request(OP_CLEAR, 16'd0, 12'd0);
		send_request(OP_ALLOC, 16'd0, 12'd0);
		send_request(OP_ALLOC, 16'd1, 12'd0);
		send_request(OP_ALLOC, 16'd16, 12'd0);
		send_request(OP_ALLOC, 16'd17, 12'hfff);
		send_request(OP_ALLOC, 16'hffff, 12'd0);
		drain();
		a = live_blocks[1];
		send_request(OP_FREE, 16'hffff, 12'd0);
		send_request(OP_FREE, 16'd0, 12'hfff);
		send_request(OP_QUERY, 16'd0, a);
		send_request(OP_FREE, 16'd0, a);
		send_request(OP_FREE, 16'd0, a);
		send_request(OP_QUERY, 16'd0, a);
		send_request(OP_QUERY, 16'd0, 12'hfff);
		send_request(3'd5, 16'hffff, 12'hfff);
		send_request(3'd6, 16'd0, 12'd0);
		send_request(3'd7, 16'h5a5a, 12'ha5a);
		send_request(OP_RELEASE, 16'd0, 12'd0);
		send_request(OP_RELEASE, 16'd0, 12'd0);
		send_request(OP_QUERY, 16'd0, 12'd1);
		drain();
	endtask

	// One phase: a clear under the given pool size, then mostly well-formed traffic.
	task automatic run_phase(logic [12:0] units, int count);
		int r;
		int unsigned span;
		write_pool_units(units);
		send_request(OP_CLEAR, 16'($urandom), 12'($urandom));
		span = (units < 3) ? 3 : (units > DEPTH ? DEPTH : units);
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(99);
			if (r < 40)
				send_request(OP_ALLOC, ($urandom_range(9) == 0) ? 16'($urandom) :
					16'($urandom_range(0, UNIT * span / 4)), 12'($urandom));
			else if (r < 65)
				send_request(OP_FREE, 16'($urandom), pick_live());
			else if (r < 80)
				send_request(OP_QUERY, 16'($urandom), pick_live());
			else if (r < 88)
				send_request(OP_FREE, 16'($urandom), 12'($urandom_range(0, span)));
			else if (r < 92)
				send_request(OP_QUERY, 16'($urandom), 12'($urandom));
			else if (r < 95)
				send_request(3'($urandom_range(5, 7)), 16'($urandom), 12'($urandom));
			else if (r < 97)
				send_request(OP_RELEASE, 16'($urandom), 12'($urandom));
			else
				send_request(OP_CLEAR, 16'($urandom), 12'($urandom));
		end
		drain();
	endtask

	task automatic test_random;
		run_phase(13'd3, 40);
		run_phase(13'd0, 30);
		run_phase(13'd8191, 60);
		run_phase(13'd4, 40);
		gaps_on = 1'b0;
		run_phase(13'($urandom_range(5, 64)), 150);
		gaps_on = 1'b1;
		for (int p = 0; p < 4; p++)
			run_phase(13'($urandom_range(16, 300)), 120);
		run_phase(13'd4096, 100);
		run_phase(13'($urandom_range(1, 2)), 30);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_before_clear();
		test_directed();
		test_random();
		drain();
		repeat (64) @(posedge clk);
		$display("Covered %0d requests, %0d results: %0d allocations, %0d out of space,",
			accepted, results, allocs_ok, no_space);
		$display("%0d frees and %0d positive queries over pool sizes from 3 to 4096 units.",
			frees_ok, queries_true);
		if (errors == 0 && pending.size() == 0)
			$display("[next_fit_block_allocator] OK");
		else
			$display("[next_fit_block_allocator] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
